// ===== rtl/device_slot_hash_probe_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the device slot hash probe core
// Shared property wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DEVICE_SLOT_HASH_PROBE_CORE_MACROS_SVH
`define DEVICE_SLOT_HASH_PROBE_CORE_MACROS_SVH

// Same-cycle implication.
`define DSHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DSHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dshp_pkg.sv =====
// ----------------------------------------------------------------------------
// dshp_pkg
// Types and constants shared by the device slot hash probe core.
// ----------------------------------------------------------------------------
package dshp_pkg;

  localparam int unsigned Slots      = 64;
  localparam int unsigned IdxW       = $clog2(Slots);
  localparam int unsigned KeyW       = 32;
  localparam int unsigned KeyShift   = 4;
  localparam int unsigned SlotFieldW = 6;
  localparam int unsigned OutDataW   = 8;
  localparam logic [KeyW-1:0] EmptyKey = '0;

  typedef logic [IdxW-1:0] slot_idx_t;
  typedef logic [KeyW-1:0] key_t;

  // Request from the probe sequencer to the key store.
  typedef struct packed {
    slot_idx_t rd_addr;
    logic      wr_en;
    slot_idx_t wr_addr;
    key_t      wr_key;
  } store_req_t;

endpackage

// ===== rtl/dshp_key_store.sv =====
// ----------------------------------------------------------------------------
// dshp_key_store
// Slot owner key memory: one write and one registered read per cycle.
// Entries never written read back as the empty key.
// ----------------------------------------------------------------------------
module dshp_key_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dshp_pkg::store_req_t req_i,
  output dshp_pkg::key_t      owner_o
);
  import dshp_pkg::*;

  key_t             mem_q [Slots];
  logic [Slots-1:0] valid_q;
  key_t             owner_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_key;
    end
  end

  // Read data gated by the entry's valid bit.
  always_ff @(posedge clk_i) begin
    owner_q <= valid_q[req_i.rd_addr] ? mem_q[req_i.rd_addr] : EmptyKey;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.wr_en) begin
      valid_q[req_i.wr_addr] <= 1'b1;
    end
  end

  assign owner_o = owner_q;

endmodule

// ===== rtl/device_slot_hash_probe_core.sv =====
// ----------------------------------------------------------------------------
// device_slot_hash_probe_core
// Find-or-insert of 32-bit device keys in a linear-probed slot table.
// ----------------------------------------------------------------------------
// Each input word carries one device key. The core hashes it to a home slot
// (key >> 4, masked to the table size) and walks the table one slot per
// cycle, wrapping from the last slot to slot 0. The first slot that holds the
// key is returned; if an empty slot comes first, the key is written there and
// that slot is returned. A key of zero returns the first empty slot and
// writes nothing. After a full pass with no match and no empty slot, the
// result word has table_full set and slot_index zero. The table starts empty
// after reset and entries are never removed.
// Timing: the accept cycle issues the first read of the key memory; each
// following cycle compares one slot and reads the next until the walk ends
// after 1 to 64 slots; a finished walk waits while the output register
// holds an untaken word. The single read port of the key memory sets this
// pace. One key is in flight at a time; a new key is taken once the previous
// result sits in the output register, even if not yet taken downstream.
// ----------------------------------------------------------------------------
module device_slot_hash_probe_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input: tdata[31:0] = device_key
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [dshp_pkg::KeyW-1:0] s_axis_tdata_i,
  // Output: tdata[5:0] = slot_index, tdata[7:6] = zero
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [dshp_pkg::OutDataW-1:0] m_axis_tdata_o,
  // Output: tuser[0] = table_full
  output logic                   m_axis_tuser_o
);
  import dshp_pkg::*;

`include "device_slot_hash_probe_core_macros.svh"

  typedef enum logic [1:0] {
    StIdle  = 2'b01,
    StProbe = 2'b10
  } state_e;

  state_e    state_q, state_d;
  key_t      key_q, key_d;
  slot_idx_t probe_q, probe_d;
  slot_idx_t cnt_q, cnt_d;

  logic                  out_valid_q, out_valid_d;
  logic [SlotFieldW-1:0] out_slot_q, out_slot_d;
  logic                  out_full_q, out_full_d;

  store_req_t req;
  key_t       owner;

  logic      in_accept;
  logic      hit_match, hit_empty, last_probe, done, can_load;
  slot_idx_t home, probe_next;

  // Home slot of the incoming key, kept inside the table by the mask.
  assign home = IdxW'((s_axis_tdata_i >> KeyShift) & KeyW'(Slots - 1));

  // Advance with wrap at the last slot.
  assign probe_next = (probe_q == IdxW'(Slots - 1)) ? '0 : probe_q + 1'b1;

  assign hit_match  = (owner == key_q);
  assign hit_empty  = (owner == EmptyKey);
  assign last_probe = (cnt_q == IdxW'(Slots - 1));
  assign done       = hit_match || hit_empty || last_probe;
  assign can_load   = !out_valid_q || m_axis_tready_i;

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    probe_d     = probe_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_slot_d  = out_slot_q;
    out_full_d  = out_full_q;

    req.rd_addr = probe_q;
    req.wr_en   = 1'b0;
    req.wr_addr = probe_q;
    req.wr_key  = key_q;

    unique case (state_q)
      StIdle: begin
        // Start the first read right away at the home slot.
        req.rd_addr = home;
        if (in_accept) begin
          key_d   = s_axis_tdata_i;
          probe_d = home;
          cnt_d   = '0;
          state_d = StProbe;
        end
      end
      StProbe: begin
        if (done) begin
          // Hold the read address so the data survives an output stall.
          if (can_load) begin
            out_valid_d = 1'b1;
            out_full_d  = !(hit_match || hit_empty);
            out_slot_d  = (hit_match || hit_empty) ? SlotFieldW'(probe_q) : '0;
            // Claim the empty slot; a match (including key zero) writes nothing.
            req.wr_en   = hit_empty && !hit_match;
            state_d     = StIdle;
          end
        end else begin
          probe_d     = probe_next;
          cnt_d       = cnt_q + 1'b1;
          req.rd_addr = probe_next;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    probe_q    <= probe_d;
    cnt_q      <= cnt_d;
    out_slot_q <= out_slot_d;
    out_full_q <= out_full_d;
  end

  dshp_key_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .owner_o (owner)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'(out_slot_q);
  assign m_axis_tuser_o  = out_full_q;

  `DSHP_ASSERT_NEXT(a_accept_starts_walk, in_accept, (state_q == StProbe) && (cnt_q == '0), "accepted key did not start a walk at probe zero")
  `DSHP_ASSERT_NOW(a_write_only_empty, req.wr_en, (owner == EmptyKey) && (key_q != EmptyKey), "slot claimed while not empty or with the empty key")
  `DSHP_ASSERT_NOW(a_full_slot_zero, out_valid_q && out_full_q, out_slot_q == '0, "overflow result carries a nonzero slot")
  `DSHP_ASSERT_NOW(a_write_ends_walk, req.wr_en, (state_q == StProbe) && (state_d == StIdle), "slot written outside the end of a walk")

endmodule
